// ===== design/bdcl_pkg.sv =====
// ----------------------------------------------------------------------------
// bdcl_pkg
// Shared types and constants for the button debounce / click / long-press block.
// ----------------------------------------------------------------------------
package bdcl_pkg;

    localparam int unsigned TIME_W    = 32;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;
    localparam int unsigned LCOUNT_W  = 16;
    localparam int unsigned CCOUNT_W  = 8;
    localparam int unsigned S_DATA_W  = 40;
    localparam int unsigned M_DATA_W  = 32;

    localparam logic [CFG_W-1:0] DEF_SETTLE = 16'd10;
    localparam logic [CFG_W-1:0] DEF_LONG   = 16'd1000;
    localparam logic [CFG_W-1:0] DEF_REPEAT = 16'd100;
    localparam logic [CFG_W-1:0] DEF_CLICK  = 16'd200;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SETTLE = 2'd0,
        REG_LONG   = 2'd1,
        REG_REPEAT = 2'd2,
        REG_CLICK  = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [CFG_W-1:0] settle_time;
        logic [CFG_W-1:0] long_press_threshold;
        logic [CFG_W-1:0] repeat_interval;
        logic [CFG_W-1:0] click_interval;
    } cfg_t;

    typedef struct packed {
        logic [CCOUNT_W-1:0] click_total;
        logic                click_event;
        logic [LCOUNT_W-1:0] long_count;
        logic                long_event;
        logic                release_event;
        logic                press_event;
        logic                key_down;
    } result_t;

endpackage

// ===== design/bdcl_cfg.sv =====
// ----------------------------------------------------------------------------
// bdcl_cfg
// Timing registers; a zero write stores the default value.
// ----------------------------------------------------------------------------
module bdcl_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             wr_en,
    input  logic [bdcl_pkg::CFG_IDX_W-1:0]   wr_index,
    input  logic [bdcl_pkg::CFG_W-1:0]       wr_data,
    output bdcl_pkg::cfg_t                   cfg
);

    bdcl_pkg::cfg_t cfg_reg;
    bdcl_pkg::cfg_t cfg_next;

    function automatic logic [bdcl_pkg::CFG_W-1:0] eff
    (
        input logic [bdcl_pkg::CFG_W-1:0] v,
        input logic [bdcl_pkg::CFG_W-1:0] dflt
    );
        return (v != '0) ? v : dflt;
    endfunction

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (bdcl_pkg::reg_idx_t'(wr_index))
                bdcl_pkg::REG_SETTLE:
                    cfg_next.settle_time = eff(wr_data, bdcl_pkg::DEF_SETTLE);
                bdcl_pkg::REG_LONG:
                    cfg_next.long_press_threshold = eff(wr_data, bdcl_pkg::DEF_LONG);
                bdcl_pkg::REG_REPEAT:
                    cfg_next.repeat_interval = eff(wr_data, bdcl_pkg::DEF_REPEAT);
                bdcl_pkg::REG_CLICK:
                    cfg_next.click_interval = eff(wr_data, bdcl_pkg::DEF_CLICK);
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.settle_time          <= bdcl_pkg::DEF_SETTLE;
            cfg_reg.long_press_threshold <= bdcl_pkg::DEF_LONG;
            cfg_reg.repeat_interval      <= bdcl_pkg::DEF_REPEAT;
            cfg_reg.click_interval       <= bdcl_pkg::DEF_CLICK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== design/bdcl_core.sv =====
// ----------------------------------------------------------------------------
// bdcl_core
// Debounce, click and long-press state with the single-poll update logic.
// ----------------------------------------------------------------------------
module bdcl_core
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           step,
    input  logic                           pin_level,
    input  logic [bdcl_pkg::TIME_W-1:0]    now_ms,
    input  bdcl_pkg::cfg_t                 cfg,
    output bdcl_pkg::result_t              result
);

    localparam int unsigned TW = bdcl_pkg::TIME_W;
    localparam int unsigned LW = bdcl_pkg::LCOUNT_W;
    localparam int unsigned CW = bdcl_pkg::CCOUNT_W;
    localparam int unsigned PW = TW - bdcl_pkg::CFG_W;

    logic          stable_level_reg,   stable_level_next;
    logic          change_pending_reg, change_pending_next;
    logic [TW-1:0] pending_since_reg,  pending_since_next;
    logic [TW-1:0] pressed_at_reg,     pressed_at_next;
    logic [TW-1:0] released_at_reg,    released_at_next;
    logic [LW-1:0] repeat_count_reg,   repeat_count_next;
    logic [TW-1:0] last_repeat_at_reg, last_repeat_at_next;
    logic [CW-1:0] click_count_reg,    click_count_next;

    logic          settle_done;
    logic          edge_ok;
    logic [LW-1:0] rc_mid;
    logic [CW-1:0] cc_mid;
    logic [TW-1:0] hold_time;
    logic [TW-1:0] repeat_time;
    logic [TW-1:0] idle_time;

    always_comb
    begin
        stable_level_next   = stable_level_reg;
        change_pending_next = change_pending_reg;
        pending_since_next  = pending_since_reg;
        pressed_at_next     = pressed_at_reg;
        released_at_next    = released_at_reg;
        last_repeat_at_next = last_repeat_at_reg;
        rc_mid              = repeat_count_reg;
        cc_mid              = click_count_reg;
        result              = '0;

        settle_done = change_pending_reg &&
                      ((now_ms - pending_since_reg) >= {{PW{1'b0}}, cfg.settle_time});
        edge_ok     = settle_done && (pin_level != stable_level_reg);

        if (change_pending_reg)
        begin
            if (settle_done)
            begin
                if (edge_ok)
                begin
                    if (pin_level)
                    begin
                        pressed_at_next    = now_ms;
                        result.press_event = 1'b1;
                    end
                    else
                    begin
                        released_at_next     = now_ms;
                        result.release_event = 1'b1;
                        rc_mid               = '0;
                        if ((now_ms - pressed_at_reg) <
                            {{PW{1'b0}}, cfg.long_press_threshold})
                        begin
                            if (click_count_reg != '1)
                                cc_mid = click_count_reg + 1'b1;
                        end
                        else
                        begin
                            cc_mid = '0;
                        end
                    end
                end
                stable_level_next   = pin_level;
                change_pending_next = 1'b0;
            end
        end
        else if (pin_level != stable_level_reg)
        begin
            change_pending_next = 1'b1;
            pending_since_next  = now_ms;
        end

        hold_time   = now_ms - pressed_at_next;
        repeat_time = now_ms - last_repeat_at_reg;
        idle_time   = now_ms - released_at_next;

        repeat_count_next = rc_mid;
        if (stable_level_next)
        begin
            if (rc_mid == '0)
            begin
                if ((pressed_at_next != '0) &&
                    (hold_time > {{PW{1'b0}}, cfg.long_press_threshold}))
                begin
                    repeat_count_next   = {{(LW-1){1'b0}}, 1'b1};
                    last_repeat_at_next = now_ms;
                    result.long_event   = 1'b1;
                    result.long_count   = {{(LW-1){1'b0}}, 1'b1};
                end
            end
            else if (repeat_time > {{PW{1'b0}}, cfg.repeat_interval})
            begin
                last_repeat_at_next = now_ms;
                if (rc_mid != '1)
                    repeat_count_next = rc_mid + 1'b1;
                result.long_event = 1'b1;
                result.long_count = (rc_mid != '1) ? rc_mid + 1'b1 : rc_mid;
            end
        end

        click_count_next = cc_mid;
        if ((cc_mid != '0) && !stable_level_next &&
            (idle_time > {{PW{1'b0}}, cfg.click_interval}))
        begin
            result.click_event = 1'b1;
            result.click_total = cc_mid;
            click_count_next   = '0;
        end

        result.key_down = stable_level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_level_reg   <= 1'b0;
            change_pending_reg <= 1'b0;
            pending_since_reg  <= '0;
            pressed_at_reg     <= '0;
            released_at_reg    <= '0;
            repeat_count_reg   <= '0;
            last_repeat_at_reg <= '0;
            click_count_reg    <= '0;
        end
        else if (step)
        begin
            stable_level_reg   <= stable_level_next;
            change_pending_reg <= change_pending_next;
            pending_since_reg  <= pending_since_next;
            pressed_at_reg     <= pressed_at_next;
            released_at_reg    <= released_at_next;
            repeat_count_reg   <= repeat_count_next;
            last_repeat_at_reg <= last_repeat_at_next;
            click_count_reg    <= click_count_next;
        end
    end

endmodule

// ===== design/button_debounce_click_longpress.sv =====
// A result beat is registered in the result register after its input beat has been
//   taken into the input register; one input beat per cycle is sustained while the master side accepts.
// The state update for a poll is combinational between the input register
//   and the result register, so back-to-back polls see the previous poll's state.
// Reset (rst_n low, asynchronous): timing registers return to 10/1000/100/200 ms,
//   all debounce and count state clears, and both pipeline registers empty.
// ----------------------------------------------------------------------------
// button_debounce_click_longpress
// Polled key debouncer with multi-click counting and long-press repeat events.
// ----------------------------------------------------------------------------
module button_debounce_click_longpress
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [0] pin_level, [32:1] now_ms, [39:33] zero
    input  logic [bdcl_pkg::S_DATA_W-1:0]       s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] key_down, [1] press_event, [2] release_event, [3] long_event,
    // [19:4] long_count, [20] click_event, [28:21] click_total, [31:29] zero
    output logic [bdcl_pkg::M_DATA_W-1:0]       m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bdcl_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bdcl_pkg::CFG_W-1:0]          cfg_data
);

    localparam int unsigned TW = bdcl_pkg::TIME_W;

    logic              in_valid_reg;
    logic              in_pin_reg;
    logic [TW-1:0]     in_now_reg;
    logic              out_valid_reg;
    bdcl_pkg::result_t out_data_reg;

    logic              advance;
    bdcl_pkg::cfg_t    cfg;
    bdcl_pkg::result_t core_result;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;

    bdcl_cfg u_cfg
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    bdcl_core u_core
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .pin_level (in_pin_reg),
        .now_ms    (in_now_reg),
        .cfg       (cfg),
        .result    (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_pin_reg <= s_tdata[0];
            in_now_reg <= s_tdata[TW:1];
        end
        if (advance)
            out_data_reg <= core_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000,
                       out_data_reg.click_total,
                       out_data_reg.click_event,
                       out_data_reg.long_count,
                       out_data_reg.long_event,
                       out_data_reg.release_event,
                       out_data_reg.press_event,
                       out_data_reg.key_down};

`ifndef SYNTH
    a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(out_data_reg.press_event && out_data_reg.release_event))
        else $error("press and release in one beat");

    a_edge_level: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && (out_data_reg.press_event || out_data_reg.long_event))
            |-> out_data_reg.key_down)
        else $error("press or long event with key up");

    a_click_up: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && out_data_reg.click_event)
            |-> (!out_data_reg.key_down && (out_data_reg.click_total != '0)))
        else $error("click report with key down or empty count");

    a_zero_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((out_data_reg.long_event || (out_data_reg.long_count == '0)) &&
                      (out_data_reg.click_event || (out_data_reg.click_total == '0))))
        else $error("count without event");
`endif

endmodule

// ===== tb/bdcl_checker.sv =====
// ----------------------------------------------------------------------------
// bdcl_checker
// Watches the poll, result and register channels of the key debouncer, predicts
// every result beat from its own copy of the debounce, click and long-press
// state, and compares each field against the oldest prediction.
// ----------------------------------------------------------------------------
module bdcl_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    input  logic                             s_tready,
    input  logic [bdcl_pkg::S_DATA_W-1:0]    s_tdata,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [bdcl_pkg::M_DATA_W-1:0]    m_tdata,
    input  logic                             cfg_valid,
    input  logic                             cfg_ready,
    input  logic [bdcl_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bdcl_pkg::CFG_W-1:0]       cfg_data,
    output int unsigned                      fail_count,
    output int unsigned                      outstanding
);

    localparam int unsigned TW = bdcl_pkg::TIME_W;
    localparam int unsigned CW = bdcl_pkg::CFG_W;

    logic [CW-1:0]                 timing_raw [4];

    logic                          key_level;
    logic                          window_open;
    logic [TW-1:0]                 window_start;
    logic [TW-1:0]                 press_at;
    logic [TW-1:0]                 release_at;
    logic [bdcl_pkg::LCOUNT_W-1:0] repeat_no;
    logic [TW-1:0]                 repeat_at;
    logic [bdcl_pkg::CCOUNT_W-1:0] clicks;

    bdcl_pkg::result_t             key_results_due [$];
    int unsigned                   fails = 0;

    function automatic logic [TW-1:0] eff_ms(input logic [CW-1:0] raw,
                                            input logic [CW-1:0] dflt);
        return (raw != '0) ? TW'(raw) : TW'(dflt);
    endfunction

    function automatic bdcl_pkg::result_t debounce_poll(input logic pin,
                                                        input logic [TW-1:0] now);
        logic [TW-1:0]     settle_ms;
        logic [TW-1:0]     long_ms;
        logic [TW-1:0]     repeat_ms;
        logic [TW-1:0]     click_ms;
        bdcl_pkg::result_t r;
        settle_ms = eff_ms(timing_raw[bdcl_pkg::REG_SETTLE], bdcl_pkg::DEF_SETTLE);
        long_ms   = eff_ms(timing_raw[bdcl_pkg::REG_LONG], bdcl_pkg::DEF_LONG);
        repeat_ms = eff_ms(timing_raw[bdcl_pkg::REG_REPEAT], bdcl_pkg::DEF_REPEAT);
        click_ms  = eff_ms(timing_raw[bdcl_pkg::REG_CLICK], bdcl_pkg::DEF_CLICK);
        r = '0;

        if (window_open)
        begin
            if (now - window_start >= settle_ms)
            begin
                if (pin != key_level)
                begin
                    if (pin)
                    begin
                        press_at = now;
                        r.press_event = 1'b1;
                    end
                    else
                    begin
                        release_at = now;
                        r.release_event = 1'b1;
                        repeat_no = '0;
                        if (now - press_at < long_ms)
                        begin
                            if (clicks != '1)
                                clicks = clicks + 1'b1;
                        end
                        else
                        begin
                            clicks = '0;
                        end
                    end
                end
                key_level = pin;
                window_open = 1'b0;
            end
        end
        else if (pin != key_level)
        begin
            window_open = 1'b1;
            window_start = now;
        end

        if (key_level)
        begin
            if (repeat_no == '0)
            begin
                if (press_at != '0 && now - press_at > long_ms)
                begin
                    repeat_no = 1;
                    repeat_at = now;
                    r.long_event = 1'b1;
                    r.long_count = repeat_no;
                end
            end
            else if (now - repeat_at > repeat_ms)
            begin
                repeat_at = now;
                if (repeat_no != '1)
                    repeat_no = repeat_no + 1'b1;
                r.long_event = 1'b1;
                r.long_count = repeat_no;
            end
        end

        if (clicks != '0 && !key_level && now - release_at > click_ms)
        begin
            r.click_event = 1'b1;
            r.click_total = clicks;
            clicks = '0;
        end

        r.key_down = key_level;
        return r;
    endfunction

    task automatic check_field(input string name, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            fails++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        bdcl_pkg::result_t want;
        bdcl_pkg::result_t got;
        if (!rst_n)
        begin
            timing_raw[bdcl_pkg::REG_SETTLE] = bdcl_pkg::DEF_SETTLE;
            timing_raw[bdcl_pkg::REG_LONG]   = bdcl_pkg::DEF_LONG;
            timing_raw[bdcl_pkg::REG_REPEAT] = bdcl_pkg::DEF_REPEAT;
            timing_raw[bdcl_pkg::REG_CLICK]  = bdcl_pkg::DEF_CLICK;
            key_level    = 1'b0;
            window_open  = 1'b0;
            window_start = '0;
            press_at     = '0;
            release_at   = '0;
            repeat_no    = '0;
            repeat_at    = '0;
            clicks       = '0;
            key_results_due.delete();
            outstanding <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got = m_tdata[$bits(bdcl_pkg::result_t)-1:0];
                if (key_results_due.size() == 0)
                begin
                    $error("result beat with no poll outstanding");
                    fails++;
                end
                else
                begin
                    want = key_results_due.pop_front();
                    check_field("key_down", want.key_down, got.key_down);
                    check_field("press_event", want.press_event, got.press_event);
                    check_field("release_event", want.release_event, got.release_event);
                    check_field("long_event", want.long_event, got.long_event);
                    check_field("long_count", want.long_count, got.long_count);
                    check_field("click_event", want.click_event, got.click_event);
                    check_field("click_total", want.click_total, got.click_total);
                end
            end
            if (cfg_valid && cfg_ready)
                timing_raw[cfg_index] = cfg_data;
            if (s_tvalid && s_tready)
                key_results_due.push_back(debounce_poll(s_tdata[0], s_tdata[TW:1]));
            outstanding <= key_results_due.size();
        end
        fail_count <= fails;
    end

endmodule

// ===== tb/tb_button_debounce_click_longpress.sv =====
// ----------------------------------------------------------------------------
// tb_button_debounce_click_longpress
// Drives polls of pin level and millisecond time into the key debouncer:
// directed edge cases and random click / long-press / bounce gestures under
// several timing settings, with random gaps and back-pressure. The checker
// beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_button_debounce_click_longpress;

    localparam int unsigned CYCLE_LIMIT = 3_000_000;
    localparam int unsigned TW = bdcl_pkg::TIME_W;
    localparam int unsigned CW = bdcl_pkg::CFG_W;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [bdcl_pkg::S_DATA_W-1:0]   s_tdata = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [bdcl_pkg::M_DATA_W-1:0]   m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [bdcl_pkg::CFG_IDX_W-1:0]  cfg_index = bdcl_pkg::REG_SETTLE;
    logic [CW-1:0]                   cfg_data = '0;

    int unsigned          fail_count;
    int unsigned          outstanding;
    int unsigned          cycle_count = 0;
    int unsigned          polls_sent = 0;
    int unsigned          stall_left = 0;
    bit                   quiet = 1'b0;

    logic [TW-1:0]        now_t = '0;
    logic [TW-1:0]        st = TW'(bdcl_pkg::DEF_SETTLE);
    logic [TW-1:0]        lt = TW'(bdcl_pkg::DEF_LONG);
    logic [TW-1:0]        ri = TW'(bdcl_pkg::DEF_REPEAT);
    logic [TW-1:0]        ci = TW'(bdcl_pkg::DEF_CLICK);

    button_debounce_click_longpress uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bdcl_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // stall the result side: mostly short, a few long, none while quiet
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            if (!quiet && $urandom_range(0, 5) == 0)
                stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                          : $urandom_range(1, 3);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [TW-1:0] eff_ms(input logic [CW-1:0] raw,
                                            input logic [CW-1:0] dflt);
        return (raw != '0) ? TW'(raw) : TW'(dflt);
    endfunction

    function automatic logic [CW-1:0] pick_timing();
        int unsigned r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        else if (r == 2)
            return 16'd1;
        else if (r < 7)
            return $urandom_range(1, 30);
        else if (r < 9)
            return $urandom_range(31, 2000);
        return $urandom_range(0, 65535);
    endfunction

    task automatic poll_at(input logic pin, input logic [TW-1:0] t);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        now_t = t;
        s_tvalid <= 1'b1;
        s_tdata <= {{(bdcl_pkg::S_DATA_W-TW-1){1'b0}}, t, pin};
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        polls_sent++;
    endtask

    task automatic poll(input logic pin, input logic [TW-1:0] adv);
        poll_at(pin, now_t + adv);
    endtask

    // hold off until every result has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    task automatic put_reg(input bdcl_pkg::reg_idx_t idx, input logic [CW-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    task automatic write_timing(input logic [CW-1:0] v_settle, v_long,
                                input logic [CW-1:0] v_repeat, v_click);
        drain();
        put_reg(bdcl_pkg::REG_SETTLE, v_settle);
        put_reg(bdcl_pkg::REG_LONG, v_long);
        put_reg(bdcl_pkg::REG_REPEAT, v_repeat);
        put_reg(bdcl_pkg::REG_CLICK, v_click);
        cfg_valid <= 1'b0;
        st = eff_ms(v_settle, bdcl_pkg::DEF_SETTLE);
        lt = eff_ms(v_long, bdcl_pkg::DEF_LONG);
        ri = eff_ms(v_repeat, bdcl_pkg::DEF_REPEAT);
        ci = eff_ms(v_click, bdcl_pkg::DEF_CLICK);
    endtask

    // open a settle window, bounce inside it, then close it
    task automatic change_level(input logic lvl);
        logic [TW-1:0] spent;
        logic [TW-1:0] step;
        logic [TW-1:0] rest;
        poll(lvl, $urandom_range(1, 4));
        spent = 0;
        repeat ($urandom_range(0, 3))
        begin
            step = $urandom_range(0, (st - 1 - spent) / 2);
            spent += step;
            poll($urandom_range(0, 1), step);
        end
        rest = st - spent;
        if (rest > 1 && $urandom_range(0, 5) == 0)
        begin
            poll(lvl, rest - 1);
            poll(lvl, $urandom_range(1, 2));
        end
        else
        begin
            poll(($urandom_range(0, 7) == 0) ? !lvl : lvl, rest + $urandom_range(0, 2));
        end
    endtask

    task automatic hold(input logic lvl, input logic [TW-1:0] dur);
        logic [TW-1:0] spent;
        logic [TW-1:0] step;
        spent = 0;
        while (spent < dur)
        begin
            step = $urandom_range(1, dur / 3 + 1);
            if (step > dur - spent)
                step = dur - spent;
            spent += step;
            poll(lvl, step);
        end
    endtask

    task automatic gesture();
        int unsigned kind;
        kind = $urandom_range(0, 9);
        if (kind < 4)
        begin
            repeat ($urandom_range(1, 4))
            begin
                change_level(1'b1);
                hold(1'b1, $urandom_range(0, lt) / (($urandom_range(0, 1) != 0) ? 1 : 4));
                change_level(1'b0);
                hold(1'b0, $urandom_range(0, ci / 2));
            end
            poll(1'b0, ci + $urandom_range(0, 2));
            if ($urandom_range(0, 1) != 0)
                poll(1'b0, $urandom_range(0, 2));
        end
        else if (kind < 6)
        begin
            change_level(1'b1);
            hold(1'b1, lt + $urandom_range(0, 2));
            repeat ($urandom_range(1, 6))
                poll(1'b1, ri + $urandom_range(0, 2));
            change_level(1'b0);
        end
        else if (kind == 6)
        begin
            repeat ($urandom_range(1, 2))
                poll(1'b0, ci + $urandom_range(0, 2) - 1);
        end
        else if (kind == 7)
        begin
            repeat ($urandom_range(2, 6))
                poll($urandom_range(0, 1), $urandom_range(0, 2 * st));
        end
        else if (kind == 8)
        begin
            if ($urandom_range(0, 2) == 0)
                poll_at($urandom_range(0, 1), '1 - $urandom_range(0, 2 * lt));
            else
                poll_at($urandom_range(0, 1), $urandom());
        end
        else
        begin
            drain();
            poll(1'b0, $urandom_range(0, ci));
        end
    endtask

    task automatic run_gestures(input int unsigned n);
        int unsigned target;
        target = polls_sent + n;
        while (polls_sent < target)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            gesture();
        end
        quiet = 1'b0;
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        poll_at(1'b0, '1);
        // bounce back: level is back at the stable value when the window closes
        poll_at(1'b1, 100);
        poll_at(1'b0, 115);
        // press accepted at time zero, across the wrap: no long press
        poll_at(1'b1, 32'hFFFF_FFF6);
        poll_at(1'b1, 32'h0000_0000);
        poll_at(1'b1, 2000);
        poll_at(1'b0, 2100);
        poll_at(1'b0, 2110);
        // long press and one repeat, both at their exact boundaries
        poll_at(1'b1, 3000);
        poll_at(1'b1, 3010);
        poll_at(1'b1, 4010);
        poll_at(1'b1, 4011);
        poll_at(1'b1, 4111);
        poll_at(1'b1, 4112);
        poll_at(1'b0, 4200);
        poll_at(1'b0, 4210);
        // double click, reported just past the click interval
        poll_at(1'b1, 10000);
        poll_at(1'b1, 10010);
        poll_at(1'b0, 10050);
        poll_at(1'b0, 10060);
        poll_at(1'b1, 10100);
        poll_at(1'b1, 10110);
        poll_at(1'b0, 10150);
        poll_at(1'b0, 10160);
        poll_at(1'b0, 10360);
        poll_at(1'b0, 10361);

        write_timing('0, '0, '0, '0);
        run_gestures(150);
        write_timing(16'd1, 16'd1, 16'd1, 16'd1);
        run_gestures(150);
        write_timing('1, '1, '1, '1);
        run_gestures(150);
        repeat (4)
        begin
            write_timing(pick_timing(), pick_timing(), pick_timing(), pick_timing());
            run_gestures(125);
        end

        drain();
        if (fail_count == 0 && outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/bdcl_pkg.sv
design/bdcl_cfg.sv
design/bdcl_core.sv
design/button_debounce_click_longpress.sv
tb/bdcl_checker.sv
tb/tb_button_debounce_click_longpress.sv
